### hdl/wpm_pkg.sv
// Shared types, constants and helpers for the wildcard pattern matcher.
// Used by wpm_store, wpm_nfa and the top level; depends on nothing.
`default_nettype none

package wpm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int POS_W       = MAX_PATTERN + 1;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CLOSE_LVLS  = $clog2(POS_W);

    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] ANY_BYTE  = 8'h3F;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_FEED = 1'b1
    } op_t;

    typedef logic [POS_W-1:0]       pos_vec_t;
    typedef logic [MAX_PATTERN-1:0] pat_vec_t;

    // template view handed from the store to the nfa
    typedef struct packed {
        pat_vec_t           star_mask;
        pat_vec_t           hit_mask;
        logic [LEN_W-1:0]   length;
        logic               overflow;
    } tmpl_info_t;

    // one accepted item, as held in the input register
    typedef struct packed {
        op_t        operation;
        logic [7:0] symbol;
        logic       has_symbol;
        logic       last;
    } item_t;

    // position i+1 is reached from i when prop[i+1] is set; parallel prefix
    function automatic pos_vec_t star_closure(input pos_vec_t seed, input pos_vec_t prop);
        pos_vec_t g;
        pos_vec_t p;
        g = seed;
        p = prop;
        for (int k = 0; k < CLOSE_LVLS; k++) begin
            g = g | (p & (g << (1 << k)));
            p = p & (p << (1 << k));
        end
        return g;
    endfunction

endpackage

`default_nettype wire

### hdl/wpm_store.sv
// Template store: bytes, length, overflow and per-position star/hit masks.
// Depends on wpm_pkg.
`default_nettype none

module wpm_store
    import wpm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       fire,
    input  wire item_t      item,
    output tmpl_info_t      info
);

    logic [7:0]       byte_reg [MAX_PATTERN];
    pat_vec_t         star_reg, star_next;
    pat_vec_t         valid_reg, valid_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;
    logic             open_reg, open_next;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;

    always_comb begin
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        valid_next = valid_reg;
        star_next  = star_reg;
        open_next  = open_reg;
        wr_en      = 1'b0;
        wr_idx     = len_reg[IDX_W-1:0];
        if (fire) begin
            if (item.operation == OP_LOAD) begin
                // a load outside an open template starts a new one
                if (!open_reg) begin
                    len_next   = '0;
                    ovf_next   = 1'b0;
                    valid_next = '0;
                end
                wr_idx = len_next[IDX_W-1:0];
                if (item.has_symbol) begin
                    if (len_next < LEN_W'(MAX_PATTERN)) begin
                        wr_en                 = 1'b1;
                        valid_next[wr_idx]    = 1'b1;
                        star_next[wr_idx]     = (item.symbol == STAR_BYTE);
                        len_next              = len_next + LEN_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                open_next = !item.last;
            end else begin
                open_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            valid_reg <= '0;
            open_reg  <= 1'b0;
        end else begin
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            valid_reg <= valid_next;
            open_reg  <= open_next;
        end
    end

    always_ff @(posedge aclk) begin
        star_reg <= star_next;
        if (wr_en) begin
            byte_reg[wr_idx] <= item.symbol;
        end
    end

    // per-position compare against the incoming word byte
    always_comb begin
        for (int p = 0; p < MAX_PATTERN; p++) begin
            info.star_mask[p] = valid_reg[p] & star_reg[p];
            info.hit_mask[p]  = valid_reg[p] & !star_reg[p] &
                                ((byte_reg[p] == ANY_BYTE) || (byte_reg[p] == item.symbol));
        end
        info.length   = len_reg;
        info.overflow = ovf_reg;
    end

endmodule

`default_nettype wire

### hdl/wpm_nfa.sv
// Active position set of the wildcard nfa, advanced once per word byte.
// Depends on wpm_pkg; takes the template view from wpm_store.
`default_nettype none

module wpm_nfa
    import wpm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        fire,
    input  wire item_t       item,
    input  wire tmpl_info_t  info,
    output logic             res_valid,
    output logic             res_match
);

    pos_vec_t active_reg, active_next;
    logic     running_reg, running_next;
    pos_vec_t prop;
    pos_vec_t start;
    pos_vec_t stepped;
    pos_vec_t cur;

    assign prop = {info.star_mask, 1'b0};

    always_comb begin
        start   = running_reg ? active_reg : star_closure(POS_W'(1), prop);
        stepped = {1'b0, start[MAX_PATTERN-1:0] & info.star_mask}
                | {start[MAX_PATTERN-1:0] & info.hit_mask, 1'b0};
        cur     = item.has_symbol ? star_closure(stepped, prop) : start;

        active_next  = active_reg;
        running_next = running_reg;
        res_valid    = 1'b0;
        if (fire) begin
            if (item.operation == OP_LOAD) begin
                running_next = 1'b0;
            end else begin
                active_next  = cur;
                running_next = !item.last;
                res_valid    = item.last;
            end
        end
        res_match = cur[info.length];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= '0;
            running_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            running_reg <= running_next;
        end
    end

endmodule

`default_nettype wire

### hdl/wildcard_pattern_matcher.sv
// Wildcard pattern matcher: checks each streamed word against a stored template
// where '?' is any one byte and '*' any run of bytes. Uses wpm_pkg, wpm_store, wpm_nfa.
//
// Usage: one input word per item on s_*. s_operation = 0 loads template bytes
// (the item with s_last = 1 closes the template), s_operation = 1 feeds word
// bytes. s_has_symbol = 0 gives an item with no byte, e.g. to end an empty word.
// Only the last item of a word gives a result on m_*: m_match and m_overflow
// (template was longer than the store and got truncated).
// Pipeline: an item sits in the input register; its state update and result
// are registered into the output register as it leaves, which it does when
// the output register is empty or m_ready is high.
// Throughput: one item per cycle while no result waits for m_ready, set by the
// bit-parallel update of the active position set (compare, step and star closure).
// Stall: while m_valid waits for m_ready the input register still fills once,
// then s_ready drops until the result is taken.
// Reset: synchronous, active low; clears the template length, overflow flag,
// the word in progress and both pipeline registers.
`default_nettype none

module wildcard_pattern_matcher
    import wpm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_operation,
    input  wire logic [7:0] s_symbol,
    input  wire logic       s_has_symbol,
    input  wire logic       s_last,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_match,
    output logic            m_overflow
);

    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg;
    logic       out_match_reg;
    logic       out_ovf_reg;
    logic       advance;
    logic       fire;
    logic       res_valid;
    logic       res_match;
    tmpl_info_t info;

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg.operation  <= op_t'(s_operation);
            in_item_reg.symbol     <= s_symbol;
            in_item_reg.has_symbol <= s_has_symbol;
            in_item_reg.last       <= s_last;
        end
    end

    wpm_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .info    (info)
    );

    wpm_nfa u_nfa (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (in_item_reg),
        .info      (info),
        .res_valid (res_valid),
        .res_match (res_match)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_match_reg <= res_match;
            out_ovf_reg   <= info.overflow;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_match    = out_match_reg;
    assign m_overflow = out_ovf_reg;

endmodule

`default_nettype wire

### hdl/wpm_checker.sv
// Port-level checks for the wildcard pattern matcher, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none

module wpm_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic m_match,
    input wire logic m_overflow
);

    // result register is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid set after reset");

    // input side only stalls behind a waiting result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("s_ready low without a stalled result");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_match) && $stable(m_overflow)))
        else $error("result changed while stalled");

endmodule

bind wildcard_pattern_matcher wpm_checker u_wpm_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_match    (m_match),
    .m_overflow (m_overflow)
);

`default_nettype wire
